// ----- hdl/b64fdt_pkg.sv -----
// Shared types, constants and text helpers for the binary64 to decimal text formatter.
package b64fdt_pkg;

   // Number format constants.
   localparam int MAX_FRACTION_DIGITS = 30;
   localparam int PREC_W              = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int DIG_IDX_W           = $clog2(MAX_FRACTION_DIGITS);
   localparam int CNT_W               = 6;
   localparam int MAN_BITS            = 52;
   localparam int EXP_BIAS            = 1023;
   localparam int BCD_DIGITS          = 20;
   localparam int DP_W                = 5;

   localparam logic [10:0] EXP_ALL1     = 11'h7FF;
   localparam logic [10:0] POINT_EXP    = 11'(EXP_BIAS + MAN_BITS);
   localparam logic [10:0] HUGE_SHIFT   = 11'(64 - MAN_BITS);
   localparam logic [10:0] WIDE_SHIFT   = 11'd128;
   localparam logic [63:0] HALF_Q64     = 64'h8000_0000_0000_0000;

   // ASCII codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // Class of a value as decided by the front end.
   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_NAN,
      KIND_INF,
      KIND_HUGE
   } kind_type;

   // One classified value, passed from the front end to the back end.
   typedef struct packed {
      kind_type           kind;
      logic               neg;
      logic [63:0]        whole;
      logic [63:0]        frac;
      logic [PREC_W-1:0]  prec;
   } job_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEXT,
      ST_FRAC,
      ST_RDEC,
      ST_RIPPLE,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_INT,
      ST_POINT,
      ST_FDIG
   } state_type;

   // Whether a special text carries a leading minus.
   function automatic logic text_prefix(input kind_type kind, input logic neg);
      text_prefix = neg && (kind != KIND_NAN);
   endfunction

   // Length of a special text, minus sign included.
   function automatic logic [2:0] text_len(input kind_type kind, input logic neg);
      logic [2:0] base;
      base = (kind == KIND_HUGE) ? 3'd6 : 3'd3;
      text_len = base + {2'b00, text_prefix(kind, neg)};
   endfunction

   // Character at a position of a special text.
   function automatic logic [7:0] text_char(input kind_type kind, input logic neg,
                                             input logic [2:0] idx);
      logic [2:0] pos;
      logic [7:0] ch;
      pos = idx - {2'b00, text_prefix(kind, neg)};
      ch  = CHAR_MINUS;
      if (text_prefix(kind, neg) && (idx == 3'd0)) begin
         ch = CHAR_MINUS;
      end else begin
         case (kind)
            KIND_NAN: begin
               case (pos)
                  3'd0:    ch = 8'h6E;
                  3'd1:    ch = 8'h61;
                  default: ch = 8'h6E;
               endcase
            end
            KIND_INF: begin
               case (pos)
                  3'd0:    ch = 8'h69;
                  3'd1:    ch = 8'h6E;
                  default: ch = 8'h66;
               endcase
            end
            default: begin
               case (pos)
                  3'd0:    ch = 8'h3C;
                  3'd1:    ch = 8'h68;
                  3'd2:    ch = 8'h75;
                  3'd3:    ch = 8'h67;
                  3'd4:    ch = 8'h65;
                  default: ch = 8'h3E;
               endcase
            end
         endcase
      end
      text_char = ch;
   endfunction

endpackage

// ----- hdl/b64fdt_front.sv -----
// Front end: accepts a value, classifies it and splits it into integer part and Q64 fraction.
module b64fdt_front import b64fdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   input  logic [5:0]  req_digits_after_point,
   output logic        push,
   output job_type     push_job,
   input  logic        q_ready
);

   logic               stage_valid_ff, stage_valid_in;
   logic [63:0]        bits_ff, bits_in;
   logic [PREC_W-1:0]  prec_ff, prec_in;
   logic               req_fire;

   logic [10:0]  expf, eb, lsh, rsh;
   logic [51:0]  manf;
   logic [52:0]  man;
   logic [127:0] wide;

   assign req_ready = !stage_valid_ff || q_ready;
   assign req_fire  = req_valid && req_ready;
   assign push      = stage_valid_ff && q_ready;

   // Input stage: hold one transaction with the precision already saturated.
   always_comb begin
      bits_in        = bits_ff;
      prec_in        = prec_ff;
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         bits_in        = req_value_bits;
         stage_valid_in = 1'b1;
         if (req_digits_after_point > 6'(MAX_FRACTION_DIGITS)) begin
            prec_in = PREC_W'(MAX_FRACTION_DIGITS);
         end else begin
            prec_in = PREC_W'(req_digits_after_point);
         end
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      bits_ff <= bits_in;
      prec_ff <= prec_in;
   end

   // Classification and alignment of the significand to the binary point.
   always_comb begin
      expf = bits_ff[62:52];
      manf = bits_ff[51:0];
      eb   = (expf == 11'd0) ? 11'd1 : expf;
      man  = {(expf != 11'd0), manf};
      lsh  = eb - POINT_EXP;
      rsh  = POINT_EXP - eb;
      wide = {11'd0, man, 64'd0} >> rsh[6:0];

      push_job.kind  = KIND_NUM;
      push_job.neg   = bits_ff[63];
      push_job.prec  = prec_ff;
      push_job.whole = 64'd0;
      push_job.frac  = 64'd0;
      if (expf == EXP_ALL1) begin
         push_job.kind = (manf != 52'd0) ? KIND_NAN : KIND_INF;
      end else if (eb >= POINT_EXP) begin
         if (lsh >= HUGE_SHIFT) begin
            push_job.kind = KIND_HUGE;
         end else begin
            push_job.whole = {11'd0, man} << lsh[3:0];
         end
      end else if (rsh < WIDE_SHIFT) begin
         push_job.whole = wide[127:64];
         push_job.frac  = wide[63:0];
      end
   end

endmodule

// ----- hdl/b64fdt_queue.sv -----
// Two-entry queue between the front end and the back end.
module b64fdt_queue import b64fdt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    q_ready,
   input  logic    pop,
   output logic    q_valid,
   output job_type q_job
);

   job_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign q_ready = (count_ff != 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_job   = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/b64fdt_back.sv -----
// Back end: fraction digits, rounding, integer conversion and character output, or the text of a special value.
module b64fdt_back import b64fdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DP_W-1:0]    dp_ff, dp_in;
   logic [2:0]         tix_ff, tix_in;
   logic [3:0]         dig_ff [MAX_FRACTION_DIGITS];
   logic [3:0]         dig_in [MAX_FRACTION_DIGITS];
   logic [4*BCD_DIGITS-1:0] bcd_ff, bcd_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic               emit_ok;
   logic [CNT_W-1:0]   rd_cnt;
   logic [3:0]         rd_dig;
   logic [67:0]        prod;
   logic               parity, bump_last;
   logic [3:0]         cur_bcd;
   logic [4*BCD_DIGITS-1:0] adj;
   logic [PREC_W-1:0]  prec_m1;

   assign emit_ok      = !out_valid_ff || rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = out_last_ff;
   assign pop          = (state_ff == ST_IDLE) && q_valid;
   assign prec_m1      = job_ff.prec - PREC_W'(1);

   // Shared digit read port and per-state arithmetic.
   always_comb begin
      rd_cnt = (state_ff == ST_FDIG) ? cnt_ff : cnt_ff - CNT_W'(1);
      if (rd_cnt < CNT_W'(MAX_FRACTION_DIGITS)) begin
         rd_dig = dig_ff[rd_cnt[DIG_IDX_W-1:0]];
      end else begin
         rd_dig = 4'd0;
      end
      prod      = {1'b0, job_ff.frac, 3'b000} + {3'b000, job_ff.frac, 1'b0};
      parity    = (job_ff.prec != '0) ? rd_dig[0] : job_ff.whole[0];
      bump_last = (job_ff.frac > HALF_Q64) || ((job_ff.frac == HALF_Q64) && parity);
      cur_bcd   = bcd_ff[4*dp_ff +: 4];
      for (int k = 0; k < BCD_DIGITS; k++) begin
         adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? bcd_ff[4*k +: 4] + 4'd3
                                                    : bcd_ff[4*k +: 4];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_job.kind == KIND_NUM) ? ST_FRAC : ST_TEXT;
            end
         end
         ST_TEXT: begin
            if (emit_ok && (tix_ff == text_len(job_ff.kind, job_ff.neg) - 3'd1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_FRAC: begin
            if (cnt_ff == CNT_W'(job_ff.prec)) begin
               state_in = ST_RDEC;
            end
         end
         ST_RDEC: begin
            state_in = bump_last ? ST_RIPPLE : ST_CONV;
         end
         ST_RIPPLE: begin
            if ((cnt_ff == '0) || (rd_dig != 4'd9)) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (cnt_ff == CNT_W'(63)) begin
               state_in = job_ff.neg ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (emit_ok) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((dp_ff == '0) || (cur_bcd != 4'd0)) begin
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            if (emit_ok && (dp_ff == '0)) begin
               state_in = (job_ff.prec != '0) ? ST_POINT : ST_IDLE;
            end
         end
         ST_POINT: begin
            if (emit_ok) begin
               state_in = ST_FDIG;
            end
         end
         ST_FDIG: begin
            if (emit_ok && (cnt_ff == CNT_W'(prec_m1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      dp_in        = dp_ff;
      tix_in       = tix_ff;
      dig_in       = dig_ff;
      bcd_in       = bcd_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               job_in = q_job;
               cnt_in = '0;
               tix_in = 3'd0;
            end
         end
         ST_TEXT: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = text_char(job_ff.kind, job_ff.neg, tix_ff);
               out_last_in  = (tix_ff == text_len(job_ff.kind, job_ff.neg) - 3'd1);
               tix_in       = tix_ff + 3'd1;
            end
         end
         ST_FRAC: begin
            // One decimal digit per cycle: the fraction times ten.
            if (cnt_ff != CNT_W'(job_ff.prec)) begin
               dig_in[cnt_ff[DIG_IDX_W-1:0]] = prod[67:64];
               job_in.frac                   = prod[63:0];
               cnt_in                        = cnt_ff + CNT_W'(1);
            end
         end
         ST_RDEC: begin
            bcd_in = '0;
            if (!bump_last) begin
               cnt_in = '0;
            end
         end
         ST_RIPPLE: begin
            // Carry walks up through trailing nines, and into the integer part if every digit was a nine.
            if (cnt_ff == '0) begin
               job_in.whole = job_ff.whole + 64'd1;
            end else if (rd_dig != 4'd9) begin
               dig_in[rd_cnt[DIG_IDX_W-1:0]] = rd_dig + 4'd1;
               cnt_in                        = '0;
            end else begin
               dig_in[rd_cnt[DIG_IDX_W-1:0]] = 4'd0;
               cnt_in                        = cnt_ff - CNT_W'(1);
            end
         end
         ST_CONV: begin
            // Shift-and-add-three conversion, one bit of the integer per cycle.
            bcd_in       = {adj[4*BCD_DIGITS-2:0], job_ff.whole[63]};
            job_in.whole = {job_ff.whole[62:0], 1'b0};
            cnt_in       = cnt_ff + CNT_W'(1);
            dp_in        = DP_W'(BCD_DIGITS - 1);
         end
         ST_SIGN: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         ST_SKIP: begin
            if ((dp_ff != '0) && (cur_bcd == 4'd0)) begin
               dp_in = dp_ff - DP_W'(1);
            end
         end
         ST_INT: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + {4'd0, cur_bcd};
               out_last_in  = (dp_ff == '0) && (job_ff.prec == '0);
               if (dp_ff != '0) begin
                  dp_in = dp_ff - DP_W'(1);
               end
            end
         end
         ST_POINT: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_POINT;
               out_last_in  = 1'b0;
               cnt_in       = '0;
            end
         end
         ST_FDIG: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + {4'd0, rd_dig};
               out_last_in  = (cnt_ff == CNT_W'(prec_m1));
               cnt_in       = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            out_valid_in = out_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff      <= job_in;
      cnt_ff      <= cnt_in;
      dp_ff       <= dp_in;
      tix_ff      <= tix_in;
      dig_ff      <= dig_in;
      bcd_ff      <= bcd_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- hdl/binary64_to_fixed_decimal_text.sv -----
// Top level of the binary64 to fixed-point decimal text formatter.
//
// Each transaction on the req_ channel carries a binary64 bit pattern and a
// count of fraction digits (saturated at 30); the rsp_ channel returns the
// value as ASCII text in "%.Nf" style, one character per transaction, with
// rsp_last on the final one. NaN gives "nan", infinities "inf" or "-inf", and
// integer parts of 2^64 or more "<huge>" or "-<huge>". A front end registers
// the value, classifies and aligns it and passes it through a two-entry queue,
// so it can take the next value while the back end is busy. The back end
// handles one value at a time: it takes the value, works out the fraction
// digits (one multiply by ten per cycle), makes one rounding decision,
// ripples any carry through trailing nines, converts the integer part from
// binary to decimal, skips leading zeros and then emits the characters one
// at a time as the output accepts them.
module binary64_to_fixed_decimal_text import b64fdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   input  logic [5:0]  req_digits_after_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   logic    push, q_ready, pop, q_valid;
   job_type push_job, q_job;

   b64fdt_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_value_bits         (req_value_bits),
      .req_digits_after_point (req_digits_after_point),
      .push                   (push),
      .push_job               (push_job),
      .q_ready                (q_ready)
   );

   b64fdt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_ready  (q_ready),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   b64fdt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_job        (q_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the binary64 to fixed-point decimal text formatter.
module tb;
   import b64fdt_pkg::*;

   // Reference formatter and queue of expected characters.
   class text_scoreboard;
      logic [7:0] exp_char[$];
      logic       exp_last[$];
      int         errors;
      int         values;
      int         chars;

      function void push(logic [7:0] c);
         exp_char.push_back(c);
         exp_last.push_back(1'b0);
      endfunction

      function void push_text(string s);
         for (int k = 0; k < s.len(); k++) begin
            push(s[k]);
         end
      endfunction

      // Work out the text of one accepted value and queue it.
      function void note_value(logic [63:0] bits, logic [5:0] dap);
         int         prec;
         logic       neg;
         logic [10:0] expf;
         logic [63:0] manf, man, whole, frac;
         int         e2, sh;
         logic [3:0] dig[MAX_FRACTION_DIGITS];
         logic [67:0] prod;
         logic       up, carry;
         string      ws;
         prec = (dap > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS : dap;
         neg  = bits[63];
         expf = bits[62:52];
         manf = {12'd0, bits[51:0]};
         values++;
         if (expf == EXP_ALL1) begin
            if (manf != 0) push_text("nan");
            else push_text(neg ? "-inf" : "inf");
         end else begin
            if (expf == 0) begin
               man = manf;
               e2  = 1 - EXP_BIAS - MAN_BITS;
            end else begin
               man = manf | (64'd1 << MAN_BITS);
               e2  = int'(expf) - EXP_BIAS - MAN_BITS;
            end
            if (e2 >= 64 || (e2 >= 0 && man > ({64{1'b1}} >> e2))) begin
               push_text(neg ? "-<huge>" : "<huge>");
            end else begin
               if (e2 >= 0) begin
                  whole = man << e2;
                  frac  = 0;
               end else if (e2 > -64) begin
                  sh    = -e2;
                  whole = man >> sh;
                  frac  = (man & ((64'd1 << sh) - 1)) << (64 - sh);
               end else begin
                  sh    = -e2 - 64;
                  whole = 0;
                  frac  = (sh < 64) ? (man >> sh) : 64'd0;
               end
               // Fraction digits by repeated multiplication by ten.
               for (int k = 0; k < prec; k++) begin
                  prod   = {4'd0, frac} * 68'd10;
                  dig[k] = prod[67:64];
                  frac   = prod[63:0];
               end
               // Round the last digit half to even.
               if (frac > HALF_Q64) up = 1'b1;
               else if (frac < HALF_Q64) up = 1'b0;
               else up = (prec > 0) ? dig[prec-1][0] : whole[0];
               if (up) begin
                  carry = 1'b1;
                  for (int k = prec - 1; k >= 0 && carry; k--) begin
                     if (dig[k] != 9) begin
                        dig[k]++;
                        carry = 1'b0;
                     end else begin
                        dig[k] = 0;
                     end
                  end
                  if (carry) whole++;
               end
               if (neg) push(CHAR_MINUS);
               ws = $sformatf("%0d", whole);
               push_text(ws);
               if (prec > 0) begin
                  push(CHAR_POINT);
                  for (int k = 0; k < prec; k++) push(CHAR_ZERO + dig[k]);
               end
            end
         end
         exp_last[exp_last.size()-1] = 1'b1;
      endfunction

      function void report_mismatch(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endfunction

      // Compare one received character with the oldest expectation.
      function void check_char(logic [7:0] c, logic l);
         chars++;
         if (exp_char.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h", c));
         end else begin
            if (exp_char[0] !== c)
               report_mismatch($sformatf("char %h, expected %h", c, exp_char[0]));
            if (exp_last[0] !== l)
               report_mismatch($sformatf("last %b, expected %b", l, exp_last[0]));
            void'(exp_char.pop_front());
            void'(exp_last.pop_front());
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value_bits = '0;
   logic [5:0]  req_digits_after_point = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;

   text_scoreboard sb = new();
   int  send_idle_pct = 10;
   int  recv_idle_pct = 88;
   bit  hold_off = 1'b0;
   longint cycles = 0;

   binary64_to_fixed_decimal_text DUT (.*);

   // Clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, and a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_char(rsp_out_char, rsp_last);
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one value and wait until it is accepted; valid stays up afterwards
   // so that back-to-back transactions need no second assignment in one step.
   task automatic send_value(logic [63:0] bits, logic [5:0] dap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_value_bits         <= bits;
      req_digits_after_point <= dap;
      do @(posedge clock); while (!req_ready);
      sb.note_value(bits, dap);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.exp_char.size() != 0) @(posedge clock);
   endtask

   // Random binary64 pattern, biased towards interesting exponents and significands with cleared low bits.
   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v[62:52] = EXP_ALL1;
         1: v[62:52] = 11'd0;
         2: v[62:52] = 11'(1023 + 60 + $urandom_range(8));
         3: v[51:0]  = v[51:0] & ~((52'd1 << $urandom_range(52)) - 1);
         default: v[62:52] = 11'(1023 - 40 + $urandom_range(100));
      endcase
      return v;
   endfunction

   // A small random precision, now and then one from the full six-bit range.
   function automatic logic [5:0] rand_prec();
      return ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8));
   endfunction

   initial begin
      logic [63:0] dir_v[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Directed cases: special values, ties, rounding carries and extremes.
      dir_v = '{64'h7FF8000000000000, 64'hFFF0000000000001, 64'h7FF0000000000000,
                64'hFFF0000000000000, 64'h43F0000000000000, 64'hC3F0000000000000,
                64'h43EFFFFFFFFFFFFF, 64'h0000000000000000, 64'h8000000000000000,
                64'h0000000000000001, 64'h000FFFFFFFFFFFFF, 64'h3FE0000000000000,
                64'h3FF8000000000000, 64'h4004000000000000, 64'h3FEFFFFFFFFFFFFF,
                64'hBFB999999999999A, 64'h4023FFFFFFFFFFFF, 64'h3F50624DD2F1A9FC,
                64'hFFEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 64'h3FF0000000000000};
      foreach (dir_v[k]) send_value(dir_v[k], (k % 3 == 0) ? 6'd0 : ((k % 3 == 1) ? 6'd63 : 6'd2));
      send_value(64'h3FE0000000000000, 6'd0);
      send_value(64'h3FB47AE147AE147B, 6'd1);
      send_value(64'h3CB0000000000000, 6'd30);
      wait_drained();
      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            hold_off = 1'b1;
            repeat (500) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 8; k++) send_value(rand_value(), rand_prec());
      join
      wait_drained();
      // Random values in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 10 : ((ph == 1) ? 88 : 0);
         recv_idle_pct = (ph == 0) ? 88 : ((ph == 1) ? 10 : 0);
         for (int k = 0; k < 108; k++) send_value(rand_value(), rand_prec());
      end
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Formatted %0d values into %0d characters, with specials, ties and stalls.",
               sb.values, sb.chars);
      if (sb.errors == 0 && sb.exp_char.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
